/* sv/ccsw_pkg.sv */
// Constants, command codes and register indexes for the chassis command slew watchdog.
`timescale 1ns / 1ps

package ccsw_pkg;

    // Behavior constants
    localparam int TRIM_LIMIT   = 20;
    localparam int TRIM_STEP    = 2;
    localparam int PHASE_PERIOD = 200;

    // Field and port widths
    localparam int SPEED_W   = 7;
    localparam int STEER_W   = 8;
    localparam int TRIM_W    = 7;
    localparam int TIMER_W   = 16;
    localparam int PHASE_W   = 8;
    localparam int MOTOR_W   = 8;
    localparam int THR_W     = 3;
    localparam int STR_W     = 2;
    localparam int TRM_W     = 2;
    localparam int SPD_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 32;

    // Register reset values
    localparam logic [SPEED_W-1:0] SPEED_NORMAL_RST = 7'd80;
    localparam logic [SPEED_W-1:0] SPEED_SLOW_RST   = 7'd20;
    localparam logic [SPEED_W-1:0] RAMP_NORMAL_RST  = 7'd12;
    localparam logic [SPEED_W-1:0] RAMP_SLOW_RST    = 7'd4;
    localparam logic [STEER_W-1:0] STEER_CENTER_RST = 8'd150;
    localparam logic [STEER_W-1:0] STEER_LEFT_RST   = 8'd120;
    localparam logic [STEER_W-1:0] STEER_RIGHT_RST  = 8'd190;
    localparam logic [TIMER_W-1:0] TIMEOUT_RST      = 16'd80;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_NORMAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SLOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_NORMAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_SLOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_CENTER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_LEFT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_RIGHT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd7;

    // Throttle group
    localparam logic [THR_W-1:0] THR_NONE    = 3'd0;
    localparam logic [THR_W-1:0] THR_OFF     = 3'd1;
    localparam logic [THR_W-1:0] THR_STOP    = 3'd2;
    localparam logic [THR_W-1:0] THR_FORWARD = 3'd3;
    localparam logic [THR_W-1:0] THR_REVERSE = 3'd4;

    // Steering group
    localparam logic [STR_W-1:0] STR_NONE   = 2'd0;
    localparam logic [STR_W-1:0] STR_CENTER = 2'd1;
    localparam logic [STR_W-1:0] STR_LEFT   = 2'd2;
    localparam logic [STR_W-1:0] STR_RIGHT  = 2'd3;

    // Trim group
    localparam logic [TRM_W-1:0] TRM_NONE  = 2'd0;
    localparam logic [TRM_W-1:0] TRM_LEFT  = 2'd1;
    localparam logic [TRM_W-1:0] TRM_RIGHT = 2'd2;
    localparam logic [TRM_W-1:0] TRM_RESET = 2'd3;

    // Speed mode group
    localparam logic [SPD_W-1:0] SPD_NONE   = 2'd0;
    localparam logic [SPD_W-1:0] SPD_SLOW   = 2'd1;
    localparam logic [SPD_W-1:0] SPD_NORMAL = 2'd2;

endpackage

/* sv/chassis_command_slew_watchdog_core.sv */
// Top level of the chassis command slew watchdog: tick register, state update, result register.
`timescale 1ns / 1ps

//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    s_tuser: command_present
//                                              s_tdata: throttle, steer, trim, speed cmds
//  m_        out        m_tvalid / m_tready    m_tdata: servo, motor1, motor2, update, slow
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
//  A tick word is captured in the input register, then the state is updated and the result
//  word loaded into the result register together: one word per cycle sustained while m_tready is high.
//  A stalled result register holds the input register, which then holds s_tready low.
//  Reset (aresetn low, synchronous) loads register defaults and clears both stages.

module chassis_command_slew_watchdog_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input ticks
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] command_present
    input  logic                                s_tuser,
    // [2:0] throttle_cmd, [4:3] steer_cmd, [6:5] trim_cmd, [8:7] speed_cmd, zero above
    input  logic [ccsw_pkg::S_DATA_W-1:0]       s_tdata,
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] servo_position, [15:8] motor1_setpoint, [23:16] motor2_setpoint,
    // [24] motor_update, [25] slow_active, zero above
    output logic [ccsw_pkg::M_DATA_W-1:0]       m_tdata,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ccsw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ccsw_pkg::CFG_DAT_W-1:0]      cfg_data
);

    localparam int MW = ccsw_pkg::MOTOR_W;
    localparam int SW = 10;  // working width for servo and slew sums

    localparam logic signed [SW-1:0] TL_W   = SW'(ccsw_pkg::TRIM_LIMIT);
    localparam logic signed [ccsw_pkg::TRIM_W-1:0] TL_T   = ccsw_pkg::TRIM_W'(ccsw_pkg::TRIM_LIMIT);
    localparam logic signed [ccsw_pkg::TRIM_W-1:0] TSTEP  = ccsw_pkg::TRIM_W'(ccsw_pkg::TRIM_STEP);
    localparam logic [ccsw_pkg::PHASE_W-1:0] PHASE_LAST =
        ccsw_pkg::PHASE_W'(ccsw_pkg::PHASE_PERIOD - 1);
    localparam logic [ccsw_pkg::TIMER_W-1:0] TIMER_MAX = '1;

    // Slew one actual value toward its request by at most step
    function automatic logic signed [MW-1:0] slew_f(
        input logic signed [MW-1:0] cur,
        input logic signed [MW-1:0] tgt,
        input logic [ccsw_pkg::SPEED_W-1:0] step
    );
        logic signed [SW-1:0] c;
        logic signed [SW-1:0] t;
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] r;
        c = {{(SW-MW){cur[MW-1]}}, cur};
        t = {{(SW-MW){tgt[MW-1]}}, tgt};
        s = {{(SW-ccsw_pkg::SPEED_W){1'b0}}, step};
        r = c;
        if (c < t) begin
            r = c + s;
            if (r > t) r = t;
        end else if (c > t) begin
            r = c - s;
            if (r < t) r = t;
        end
        return r[MW-1:0];
    endfunction

    // Configuration registers
    logic [ccsw_pkg::SPEED_W-1:0] spd_norm_reg, spd_slow_reg, ramp_norm_reg, ramp_slow_reg;
    logic [ccsw_pkg::STEER_W-1:0] str_center_reg, str_left_reg, str_right_reg;
    logic [ccsw_pkg::TIMER_W-1:0] timeout_reg;

    // Block state
    logic [ccsw_pkg::PHASE_W-1:0]        phase_reg, phase_next;
    logic signed [MW-1:0]                req1_reg, req1_next, req2_reg, req2_next;
    logic signed [MW-1:0]                act1_reg, act1_next, act2_reg, act2_next;
    logic [ccsw_pkg::STEER_W-1:0]        base_reg, base_next;
    logic signed [ccsw_pkg::TRIM_W-1:0]  trim_reg, trim_next;
    logic                                slow_reg, slow_next;
    logic [ccsw_pkg::TIMER_W-1:0]        mtim_reg, mtim_next, stim_reg, stim_next;
    logic [ccsw_pkg::STEER_W-1:0]        servo_reg, servo_next;
    logic                                upd_next;

    // Pipeline registers
    logic                          in_vld_reg;
    logic                          pres_reg;
    logic [ccsw_pkg::THR_W-1:0]    thr_reg;
    logic [ccsw_pkg::STR_W-1:0]    str_reg;
    logic [ccsw_pkg::TRM_W-1:0]    trm_reg;
    logic [ccsw_pkg::SPD_W-1:0]    spd_reg;
    logic                          out_vld_reg;
    logic [ccsw_pkg::M_DATA_W-1:0] out_data_reg;

    logic fire;
    logic s_fire;

    assign fire      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || fire;
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spd_norm_reg   <= ccsw_pkg::SPEED_NORMAL_RST;
            spd_slow_reg   <= ccsw_pkg::SPEED_SLOW_RST;
            ramp_norm_reg  <= ccsw_pkg::RAMP_NORMAL_RST;
            ramp_slow_reg  <= ccsw_pkg::RAMP_SLOW_RST;
            str_center_reg <= ccsw_pkg::STEER_CENTER_RST;
            str_left_reg   <= ccsw_pkg::STEER_LEFT_RST;
            str_right_reg  <= ccsw_pkg::STEER_RIGHT_RST;
            timeout_reg    <= ccsw_pkg::TIMEOUT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ccsw_pkg::REG_SPEED_NORMAL: spd_norm_reg   <= cfg_data[ccsw_pkg::SPEED_W-1:0];
                ccsw_pkg::REG_SPEED_SLOW:   spd_slow_reg   <= cfg_data[ccsw_pkg::SPEED_W-1:0];
                ccsw_pkg::REG_RAMP_NORMAL:  ramp_norm_reg  <= cfg_data[ccsw_pkg::SPEED_W-1:0];
                ccsw_pkg::REG_RAMP_SLOW:    ramp_slow_reg  <= cfg_data[ccsw_pkg::SPEED_W-1:0];
                ccsw_pkg::REG_STEER_CENTER: str_center_reg <= cfg_data[ccsw_pkg::STEER_W-1:0];
                ccsw_pkg::REG_STEER_LEFT:   str_left_reg   <= cfg_data[ccsw_pkg::STEER_W-1:0];
                ccsw_pkg::REG_STEER_RIGHT:  str_right_reg  <= cfg_data[ccsw_pkg::STEER_W-1:0];
                ccsw_pkg::REG_TIMEOUT:      timeout_reg    <= cfg_data[ccsw_pkg::TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    // Tick update: commands, timers, servo, phase and slew
    always_comb begin
        logic [ccsw_pkg::SPEED_W-1:0]       sp;
        logic signed [MW-1:0]               sp_pos;
        logic signed [MW-1:0]               sp_neg;
        logic                               applied;
        logic signed [ccsw_pkg::TRIM_W:0]   trim_sum;
        logic signed [SW-1:0]               v;
        logic signed [SW-1:0]               lo;
        logic signed [SW-1:0]               hi;
        logic [ccsw_pkg::PHASE_W-1:0]       ph1;
        logic [ccsw_pkg::SPEED_W-1:0]       step;

        sp      = slow_reg ? spd_slow_reg : spd_norm_reg;
        sp_pos  = {1'b0, sp};
        sp_neg  = -sp_pos;
        applied = 1'b0;

        req1_next = req1_reg;
        req2_next = req2_reg;
        base_next = base_reg;
        trim_next = trim_reg;
        slow_next = slow_reg;
        mtim_next = mtim_reg;
        stim_next = stim_reg;
        trim_sum  = '0;

        if (pres_reg) begin
            // throttle group
            unique case (thr_reg)
                ccsw_pkg::THR_OFF: begin
                    req1_next = '0;
                    req2_next = '0;
                end
                ccsw_pkg::THR_STOP: begin
                    req1_next = '0;
                    req2_next = '0;
                    base_next = str_center_reg;
                    applied   = 1'b1;
                    mtim_next = timeout_reg;
                    stim_next = timeout_reg;
                end
                ccsw_pkg::THR_FORWARD: begin
                    req1_next = sp_neg;
                    req2_next = sp_pos;
                    mtim_next = '0;
                end
                ccsw_pkg::THR_REVERSE: begin
                    req1_next = sp_pos;
                    req2_next = sp_neg;
                    mtim_next = '0;
                end
                default: ;
            endcase

            // steering group
            unique case (str_reg)
                ccsw_pkg::STR_NONE: ;
                ccsw_pkg::STR_CENTER: begin
                    base_next = str_center_reg;
                    applied   = 1'b1;
                end
                ccsw_pkg::STR_LEFT: begin
                    base_next = str_left_reg;
                    applied   = 1'b1;
                    stim_next = '0;
                end
                ccsw_pkg::STR_RIGHT: begin
                    base_next = str_right_reg;
                    applied   = 1'b1;
                    stim_next = '0;
                end
            endcase

            // trim group
            unique case (trm_reg)
                ccsw_pkg::TRM_NONE: ;
                ccsw_pkg::TRM_LEFT: begin
                    trim_sum  = {trim_reg[ccsw_pkg::TRIM_W-1], trim_reg}
                              - {TSTEP[ccsw_pkg::TRIM_W-1], TSTEP};
                    trim_next = (trim_sum < -$signed({TL_T[ccsw_pkg::TRIM_W-1], TL_T}))
                              ? -TL_T : trim_sum[ccsw_pkg::TRIM_W-1:0];
                    applied   = 1'b1;
                end
                ccsw_pkg::TRM_RIGHT: begin
                    trim_sum  = {trim_reg[ccsw_pkg::TRIM_W-1], trim_reg}
                              + {TSTEP[ccsw_pkg::TRIM_W-1], TSTEP};
                    trim_next = (trim_sum > $signed({TL_T[ccsw_pkg::TRIM_W-1], TL_T}))
                              ? TL_T : trim_sum[ccsw_pkg::TRIM_W-1:0];
                    applied   = 1'b1;
                end
                ccsw_pkg::TRM_RESET: begin
                    trim_next = '0;
                    applied   = 1'b1;
                end
            endcase

            // speed mode group
            unique case (spd_reg)
                ccsw_pkg::SPD_SLOW:   slow_next = 1'b1;
                ccsw_pkg::SPD_NORMAL: slow_next = 1'b0;
                default: ;
            endcase
        end

        // idle timers, saturating, then timeouts
        if (mtim_next != TIMER_MAX) mtim_next = mtim_next + 1'b1;
        if (stim_next != TIMER_MAX) stim_next = stim_next + 1'b1;
        if (mtim_next > timeout_reg) begin
            req1_next = '0;
            req2_next = '0;
        end
        if (stim_next > timeout_reg) begin
            base_next = str_center_reg;
            applied   = 1'b1;
        end

        // servo: final base plus final trim, clamped to the steering window, then to a byte
        v  = $signed({{(SW-ccsw_pkg::STEER_W){1'b0}}, base_next})
           + {{(SW-ccsw_pkg::TRIM_W){trim_next[ccsw_pkg::TRIM_W-1]}}, trim_next};
        lo = $signed({{(SW-ccsw_pkg::STEER_W){1'b0}}, str_left_reg}) - TL_W;
        hi = $signed({{(SW-ccsw_pkg::STEER_W){1'b0}}, str_right_reg}) + TL_W;
        if (v < lo)      v = lo;
        else if (v > hi) v = hi;
        if (v[SW-1])                             servo_next = '0;
        else if (v[SW-2:ccsw_pkg::STEER_W] != 0) servo_next = '1;
        else                                     servo_next = v[ccsw_pkg::STEER_W-1:0];
        if (!applied) servo_next = servo_reg;

        // phase and slew on odd phase
        ph1        = phase_reg + 1'b1;
        upd_next   = ph1[0];
        phase_next = (ph1 == PHASE_LAST) ? '0 : ph1;
        step       = slow_next ? ramp_slow_reg : ramp_norm_reg;
        act1_next  = upd_next ? slew_f(act1_reg, req1_next, step) : act1_reg;
        act2_next  = upd_next ? slew_f(act2_reg, req2_next, step) : act2_reg;
    end

    // Input register, state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= '0;
            req1_reg    <= '0;
            req2_reg    <= '0;
            act1_reg    <= '0;
            act2_reg    <= '0;
            base_reg    <= ccsw_pkg::STEER_CENTER_RST;
            trim_reg    <= '0;
            slow_reg    <= 1'b0;
            mtim_reg    <= '0;
            stim_reg    <= '0;
            servo_reg   <= ccsw_pkg::STEER_CENTER_RST;
        end else begin
            if (s_tready) in_vld_reg <= s_tvalid;
            if (fire) begin
                out_vld_reg <= 1'b1;
                phase_reg   <= phase_next;
                req1_reg    <= req1_next;
                req2_reg    <= req2_next;
                act1_reg    <= act1_next;
                act2_reg    <= act2_next;
                base_reg    <= base_next;
                trim_reg    <= trim_next;
                slow_reg    <= slow_next;
                mtim_reg    <= mtim_next;
                stim_reg    <= stim_next;
                servo_reg   <= servo_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pres_reg <= s_tuser;
            thr_reg  <= s_tdata[2:0];
            str_reg  <= s_tdata[4:3];
            trm_reg  <= s_tdata[6:5];
            spd_reg  <= s_tdata[8:7];
        end
        if (fire) begin
            out_data_reg <= {6'b0, slow_next, upd_next, act2_next, act1_next, servo_next};
        end
    end

`ifndef SYNTHESIS
    // trim stays inside its limits
    a_trim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (trim_reg <= TL_T) && (trim_reg >= -TL_T))
        else $error("trim offset out of range");

    // phase never reaches the wrap value
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg < PHASE_LAST)
        else $error("tick phase out of range");

    // no state change while a result is stalled
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_tready) |=> ($stable(act1_reg) && $stable(phase_reg)))
        else $error("state moved under a stalled result");

    // update flag of a result follows the odd phase that produced it
    a_update_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (out_data_reg[24] == phase_reg[0] || phase_reg == '0))
        else $error("update flag does not match phase");
`endif

endmodule

/* dv/chassis_command_slew_watchdog_core_test.sv */
// Self-checking testbench for the chassis command slew watchdog: ticks in, predicted setpoints out.
`timescale 1ns / 1ps

module chassis_command_slew_watchdog_core_test;

    import ccsw_pkg::*;

    // Throttle and speed codes the block must ignore
    localparam logic [THR_W-1:0] THR_SPARE_5 = 3'd5;
    localparam logic [THR_W-1:0] THR_SPARE_6 = 3'd6;
    localparam logic [THR_W-1:0] THR_SPARE_7 = 3'd7;
    localparam logic [SPD_W-1:0] SPD_SPARE   = 2'd3;

    localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
    localparam int TIMER_CEILING = 65535;
    localparam int PRINT_CAP     = 40;

    // Command groups; throttle ends up in the low bits of s_tdata
    typedef struct packed {
        logic [SPD_W-1:0] speed;
        logic [TRM_W-1:0] trim;
        logic [STR_W-1:0] steer;
        logic [THR_W-1:0] throttle;
    } command_word_t;

    typedef struct packed {
        logic          present;
        command_word_t cmd;
    } tick_t;

    // Same layout as m_tdata[25:0]
    typedef struct packed {
        logic                       slow;
        logic                       update;
        logic signed [MOTOR_W-1:0]  motor2;
        logic signed [MOTOR_W-1:0]  motor1;
        logic [STEER_W-1:0]         servo;
    } chassis_output_t;

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic                    s_tuser   = 1'b0;
    logic [S_DATA_W-1:0]     s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_DATA_W-1:0]     m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DAT_W-1:0]    cfg_data  = '0;

    chassis_command_slew_watchdog_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register mirror
    int speed_normal_r, speed_slow_r, ramp_normal_r, ramp_slow_r;
    int steer_center_r, steer_left_r, steer_right_r, timeout_r;

    // Chassis state mirror
    logic [PHASE_W-1:0] tick_phase_q;
    int                 motor1_goal, motor2_goal, motor1_now, motor2_now;
    int                 steer_base_pos, trim_pos;
    logic               slow_sel;
    int                 motor_idle, steer_idle;
    logic [STEER_W-1:0] servo_pos;

    // Bookkeeping
    tick_t           tick_backlog[$];
    chassis_output_t predicted_outputs[$];
    int              ticks_issued   = 0;
    int              ticks_accepted = 0;
    int              mismatch_count = 0;
    int              quiet_cycles   = 0;
    int              calm_left      = 0;
    int              idle_mode      = 0;   // 0: sender 36/receiver 49, 1: swapped, 2: none
    logic            tick_taken     = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void set_steer_base(input int base);
        int pos, lo, hi;
        lo = steer_left_r - TRIM_LIMIT;
        hi = steer_right_r + TRIM_LIMIT;
        steer_base_pos = base;
        pos = base + trim_pos;
        if (pos < lo)
            pos = lo;
        else if (pos > hi)
            pos = hi;
        if (pos < 0)
            pos = 0;
        if (pos > 255)
            pos = 255;
        servo_pos = pos[STEER_W-1:0];
    endfunction

    function automatic int slew_toward(input int cur, input int goal, input int rate);
        int nxt;
        nxt = cur;
        if (cur < goal) begin
            nxt = cur + rate;
            if (nxt > goal)
                nxt = goal;
        end else if (cur > goal) begin
            nxt = cur - rate;
            if (nxt < goal)
                nxt = goal;
        end
        return nxt;
    endfunction

    // One control tick: command groups, timers, phase and slew
    function automatic chassis_output_t advance_chassis(input tick_t t);
        chassis_output_t r;
        int              mag, rate;
        if (t.present) begin
            mag = slow_sel ? speed_slow_r : speed_normal_r;
            case (t.cmd.throttle)
                THR_OFF: begin
                    motor1_goal = 0;
                    motor2_goal = 0;
                end
                THR_STOP: begin
                    motor1_goal = 0;
                    motor2_goal = 0;
                    set_steer_base(steer_center_r);
                    motor_idle = timeout_r;
                    steer_idle = timeout_r;
                end
                THR_FORWARD: begin
                    motor1_goal = -mag;
                    motor2_goal = mag;
                    motor_idle  = 0;
                end
                THR_REVERSE: begin
                    motor1_goal = mag;
                    motor2_goal = -mag;
                    motor_idle  = 0;
                end
                default: ;
            endcase
            case (t.cmd.steer)
                STR_CENTER: set_steer_base(steer_center_r);
                STR_LEFT: begin
                    set_steer_base(steer_left_r);
                    steer_idle = 0;
                end
                STR_RIGHT: begin
                    set_steer_base(steer_right_r);
                    steer_idle = 0;
                end
                default: ;
            endcase
            case (t.cmd.trim)
                TRM_LEFT: begin
                    trim_pos = trim_pos - TRIM_STEP;
                    if (trim_pos < -TRIM_LIMIT)
                        trim_pos = -TRIM_LIMIT;
                    set_steer_base(steer_base_pos);
                end
                TRM_RIGHT: begin
                    trim_pos = trim_pos + TRIM_STEP;
                    if (trim_pos > TRIM_LIMIT)
                        trim_pos = TRIM_LIMIT;
                    set_steer_base(steer_base_pos);
                end
                TRM_RESET: begin
                    trim_pos = 0;
                    set_steer_base(steer_base_pos);
                end
                default: ;
            endcase
            case (t.cmd.speed)
                SPD_SLOW:   slow_sel = 1'b1;
                SPD_NORMAL: slow_sel = 1'b0;
                default: ;
            endcase
        end

        // idle timers saturate instead of wrapping
        if (motor_idle < TIMER_CEILING)
            motor_idle++;
        if (steer_idle < TIMER_CEILING)
            steer_idle++;
        if (motor_idle > timeout_r) begin
            motor1_goal = 0;
            motor2_goal = 0;
        end
        if (steer_idle > timeout_r)
            set_steer_base(steer_center_r);

        // odd phases step the actual values
        tick_phase_q = tick_phase_q + 1'b1;
        r.update = tick_phase_q[0];
        if (r.update) begin
            rate = slow_sel ? ramp_slow_r : ramp_normal_r;
            motor1_now = slew_toward(motor1_now, motor1_goal, rate);
            motor2_now = slew_toward(motor2_now, motor2_goal, rate);
        end
        if ((int'(tick_phase_q) + 1) % PHASE_PERIOD == 0)
            tick_phase_q = '0;

        r.servo  = servo_pos;
        r.motor1 = motor1_now[MOTOR_W-1:0];
        r.motor2 = motor2_now[MOTOR_W-1:0];
        r.slow   = slow_sel;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            flag_mismatch(what, got, want);
    endtask

    // Monitor: result words against predictions, accepted ticks into the predictor
    always @(posedge aclk) begin : watch_streams
        chassis_output_t want;
        tick_t           seen;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (predicted_outputs.size() == 0) begin
                    flag_mismatch("result word with nothing outstanding", int'(m_tdata), 0);
                end else begin
                    want = predicted_outputs.pop_front();
                    check_field("servo_position", m_tdata[7:0], want.servo);
                    check_field("motor1_setpoint", $signed(m_tdata[15:8]), want.motor1);
                    check_field("motor2_setpoint", $signed(m_tdata[23:16]), want.motor2);
                    check_field("motor_update", m_tdata[24], want.update);
                    check_field("slow_active", m_tdata[25], want.slow);
                end
            end
            if (s_tvalid && s_tready) begin
                seen.present = s_tuser;
                seen.cmd     = s_tdata[$bits(command_word_t)-1:0];
                predicted_outputs.push_back(advance_chassis(seen));
                ticks_accepted++;
            end
        end
        tick_taken <= aresetn && s_tvalid && s_tready;
    end

    // Watchdog: no handshake on any channel for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------- driving

    function automatic bit holds_off(input int pct);
        return (calm_left == 0) && ($urandom_range(99) < pct);
    endfunction

    // Tick driver: holds a word until taken, then maybe rests
    always @(negedge aclk) begin : drive_ticks
        tick_t next_tick;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || tick_taken) begin
            if (tick_backlog.size() != 0 &&
                !holds_off(idle_mode == 0 ? 36 : (idle_mode == 1 ? 49 : 0))) begin
                next_tick = tick_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_tick.present;
                s_tdata  <= {{(S_DATA_W - $bits(command_word_t)){1'b0}}, next_tick.cmd};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        // occasional stretches where neither side idles
        if (calm_left > 0)
            calm_left <= calm_left - 1;
        else if ($urandom_range(149) == 0)
            calm_left <= $urandom_range(80, 30);
    end

    // Result back-pressure
    always @(negedge aclk) begin
        m_tready <= !holds_off(idle_mode == 0 ? 49 : (idle_mode == 1 ? 36 : 0));
    end

    // ---------------------------------------------------------------- stimulus

    function automatic tick_t make_tick(input logic present, input logic [THR_W-1:0] thr,
                                        input logic [STR_W-1:0] str,
                                        input logic [TRM_W-1:0] trm,
                                        input logic [SPD_W-1:0] spd);
        tick_t t;
        t.present      = present;
        t.cmd.throttle = thr;
        t.cmd.steer    = str;
        t.cmd.trim     = trm;
        t.cmd.speed    = spd;
        return t;
    endfunction

    function automatic tick_t random_tick();
        return make_tick($urandom_range(99) < 85, THR_W'($urandom_range(7)),
                         STR_W'($urandom_range(3)), TRM_W'($urandom_range(3)),
                         SPD_W'($urandom_range(3)));
    endfunction

    task automatic queue_word(input tick_t t);
        tick_backlog.push_back(t);
        ticks_issued++;
    endtask

    // Random ticks in runs: singles, silent stretches, trim sweeps, held throttle
    task automatic fill_random(input int count);
        int                made, kind, run_len, cap;
        tick_t             t;
        logic [TRM_W-1:0]  sweep_dir;
        logic [THR_W-1:0]  drive_dir;
        made = 0;
        while (made < count) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                queue_word(random_tick());
                made++;
            end else if (kind < 85) begin
                // silent stretch of up to three ticks past the timeout (at most 90), so the timers may expire
                cap = (timeout_r + 3 > 90) ? 90 : timeout_r + 3;
                run_len = $urandom_range(cap, 1);
                repeat (run_len) begin
                    t = random_tick();
                    t.present = 1'b0;
                    queue_word(t);
                end
                made += run_len;
            end else if (kind < 95) begin
                // trim sweep toward a limit
                sweep_dir = $urandom_range(1) ? TRM_LEFT : TRM_RIGHT;
                run_len = $urandom_range(13, 11);
                repeat (run_len) begin
                    t = random_tick();
                    t.present  = 1'b1;
                    t.cmd.trim = sweep_dir;
                    queue_word(t);
                end
                made += run_len;
            end else begin
                // held throttle so the setpoints move toward their requests
                drive_dir = $urandom_range(1) ? THR_FORWARD : THR_REVERSE;
                run_len = $urandom_range(30, 5);
                repeat (run_len) begin
                    t = random_tick();
                    t.present      = 1'b1;
                    t.cmd.throttle = drive_dir;
                    queue_word(t);
                end
                made += run_len;
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (ticks_accepted != ticks_issued || predicted_outputs.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DAT_W-1:0];
        do
            @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            REG_SPEED_NORMAL: speed_normal_r = value & 'h7f;
            REG_SPEED_SLOW:   speed_slow_r   = value & 'h7f;
            REG_RAMP_NORMAL:  ramp_normal_r  = value & 'h7f;
            REG_RAMP_SLOW:    ramp_slow_r    = value & 'h7f;
            REG_STEER_CENTER: steer_center_r = value & 'hff;
            REG_STEER_LEFT:   steer_left_r   = value & 'hff;
            REG_STEER_RIGHT:  steer_right_r  = value & 'hff;
            REG_TIMEOUT:      timeout_r      = value & 'hffff;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sequence of phases
    initial begin
        speed_normal_r = SPEED_NORMAL_RST;
        speed_slow_r   = SPEED_SLOW_RST;
        ramp_normal_r  = RAMP_NORMAL_RST;
        ramp_slow_r    = RAMP_SLOW_RST;
        steer_center_r = STEER_CENTER_RST;
        steer_left_r   = STEER_LEFT_RST;
        steer_right_r  = STEER_RIGHT_RST;
        timeout_r      = TIMEOUT_RST;
        tick_phase_q   = '0;
        motor1_goal    = 0;
        motor2_goal    = 0;
        motor1_now     = 0;
        motor2_now     = 0;
        steer_base_pos = STEER_CENTER_RST;
        trim_pos       = 0;
        slow_sel       = 1'b0;
        motor_idle     = 0;
        steer_idle     = 0;
        servo_pos      = STEER_CENTER_RST;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed ticks at reset settings
        idle_mode = 0;
        queue_word(make_tick(1'b0, THR_FORWARD, STR_LEFT, TRM_LEFT, SPD_SLOW));
        queue_word(make_tick(1'b1, THR_FORWARD, STR_LEFT, TRM_LEFT, SPD_NONE));
        queue_word(make_tick(1'b1, THR_REVERSE, STR_RIGHT, TRM_LEFT, SPD_SLOW));
        queue_word(make_tick(1'b1, THR_OFF, STR_CENTER, TRM_LEFT, SPD_NORMAL));
        queue_word(make_tick(1'b1, THR_SPARE_5, STR_LEFT, TRM_LEFT, SPD_SPARE));
        queue_word(make_tick(1'b1, THR_SPARE_6, STR_NONE, TRM_LEFT, SPD_NONE));
        queue_word(make_tick(1'b1, THR_SPARE_7, STR_RIGHT, TRM_LEFT, SPD_NONE));
        // keep trimming left past the limit
        repeat (5)
            queue_word(make_tick(1'b1, THR_NONE, STR_NONE, TRM_LEFT, SPD_NONE));
        queue_word(make_tick(1'b1, THR_FORWARD, STR_LEFT, TRM_LEFT, SPD_NONE));
        // stop together with a steer command on the same tick
        queue_word(make_tick(1'b1, THR_STOP, STR_RIGHT, TRM_RESET, SPD_NONE));
        queue_word(make_tick(1'b1, THR_STOP, STR_NONE, TRM_RIGHT, SPD_SLOW));
        repeat (3)
            queue_word(make_tick(1'b1, THR_REVERSE, STR_RIGHT, TRM_RIGHT, SPD_NONE));
        queue_word(make_tick(1'b1, THR_NONE, STR_CENTER, TRM_RESET, SPD_NORMAL));
        queue_word(make_tick(1'b0, THR_SPARE_7, STR_RIGHT, TRM_RESET, SPD_SPARE));
        queue_word(make_tick(1'b1, THR_SPARE_7, STR_RIGHT, TRM_RESET, SPD_SPARE));
        queue_word(make_tick(1'b0, THR_NONE, STR_NONE, TRM_NONE, SPD_NONE));
        fill_random(380);
        wait_drained();

        // Extremes: fast and hard, tightest timeout, lowest center
        write_register(REG_SPEED_NORMAL, 127);
        write_register(REG_SPEED_SLOW, 0);
        write_register(REG_RAMP_NORMAL, 127);
        write_register(REG_RAMP_SLOW, 1);
        write_register(REG_STEER_CENTER, 20);
        write_register(REG_STEER_LEFT, 20);
        write_register(REG_STEER_RIGHT, 235);
        write_register(REG_TIMEOUT, 1);
        fill_random(350);
        wait_drained();

        // Opposite extremes: crossed clamp window, longest timeout
        idle_mode = 1;
        write_register(REG_SPEED_NORMAL, 0);
        write_register(REG_SPEED_SLOW, 127);
        write_register(REG_RAMP_NORMAL, 1);
        write_register(REG_RAMP_SLOW, 127);
        write_register(REG_STEER_CENTER, 235);
        write_register(REG_STEER_LEFT, 235);
        write_register(REG_STEER_RIGHT, 20);
        write_register(REG_TIMEOUT, 65534);
        fill_random(350);
        wait_drained();

        // Zero ramp: setpoints frozen while requests move
        write_register(REG_RAMP_NORMAL, 0);
        write_register(REG_RAMP_SLOW, 0);
        write_register(REG_SPEED_NORMAL, $urandom_range(127, 1));
        write_register(REG_STEER_LEFT, 120);
        write_register(REG_STEER_RIGHT, 190);
        write_register(REG_TIMEOUT, 5);
        fill_random(150);
        wait_drained();

        // Random settings, short timeouts, no idling
        idle_mode = 2;
        repeat (5) begin
            write_register(REG_SPEED_NORMAL, $urandom_range(127));
            write_register(REG_SPEED_SLOW, $urandom_range(127));
            write_register(REG_RAMP_NORMAL, $urandom_range(127, 1));
            write_register(REG_RAMP_SLOW, $urandom_range(127, 1));
            write_register(REG_STEER_CENTER, $urandom_range(235, 20));
            write_register(REG_STEER_LEFT, $urandom_range(235, 20));
            write_register(REG_STEER_RIGHT, $urandom_range(235, 20));
            write_register(REG_TIMEOUT, $urandom_range(60, 1));
            fill_random(110);
            wait_drained();
        end

        // allow time for stray result words before the verdict
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
